// ===== rtl/core/mmaf_pkg.sv =====
// ----------------------------------------------------------------------------
// mmaf_pkg
// Shared constants, codes and item types of the multichannel moving-average
// filter.
// ----------------------------------------------------------------------------
package mmaf_pkg;

    localparam int CHANNELS    = 4;
    localparam int MAX_LAGS    = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;

    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LAG_W      = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
    localparam int SLOTS      = MAX_LAGS + 1;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int HIST_DEPTH = SLOTS * CHANNELS;
    localparam int HA_W       = $clog2(HIST_DEPTH);
    localparam int COEF_DEPTH = MAX_LAGS * CHANNELS * CHANNELS;
    localparam int CA_W       = $clog2(COEF_DEPTH);
    localparam int NLAG_W     = $clog2(MAX_LAGS + 1);
    localparam int NCH_W      = $clog2(CHANNELS + 1);
    localparam int PROD_W     = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W      = PROD_W + $clog2(MAX_LAGS * CHANNELS) + 2;

    // Field widths of the request and result items.
    localparam int REQ_W     = 2;
    localparam int LAG_FLD_W = 3;
    localparam int ROW_W     = 2;
    localparam int COL_W     = 2;
    localparam int OCH_W     = 2;

    // Configuration port.
    localparam int FRAC_W     = 4;
    localparam int LAGS_CFG_W = 4;
    localparam int CHAN_CFG_W = 3;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAC  = 2'd0,
        CFG_LAGS  = 2'd1,
        CFG_CHANS = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SAMPLE,
        OP_CLEAR
    } op_kind_t;

    typedef struct packed {
        logic [REQ_W-1:0]             req_type;
        logic [LAG_FLD_W-1:0]         coef_lag;
        logic [ROW_W-1:0]             coef_row;
        logic [COL_W-1:0]             coef_col;
        logic signed [COEF_BITS-1:0]  coef_value;
        logic signed [SAMPLE_BITS-1:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_value;
        logic [OCH_W-1:0]              out_channel;
        logic                          out_saturated;
        logic                          out_last_of_vector;
    } out_item_t;

    typedef struct packed {
        op_kind_t                      kind;
        logic [CA_W-1:0]               coef_addr;
        logic signed [COEF_BITS-1:0]   coef_value;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CH_W-1:0]               chan;
        logic [SLOT_W-1:0]             slot;
        logic                          last;
    } op_t;

    typedef struct packed {
        logic [FRAC_W-1:0] frac;
        logic [NLAG_W-1:0] lags;
        logic [NCH_W-1:0]  chans;
    } cfg_t;

endpackage

// ===== rtl/core/mmaf_in_if.sv =====
// ----------------------------------------------------------------------------
// mmaf_in_if
// Request channel: valid, ready and one request item.
// ----------------------------------------------------------------------------
interface mmaf_in_if import mmaf_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/mmaf_out_if.sv =====
// ----------------------------------------------------------------------------
// mmaf_out_if
// Result channel: valid, ready and one filtered sample.
// ----------------------------------------------------------------------------
interface mmaf_out_if import mmaf_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/mmaf_ram.sv =====
// ----------------------------------------------------------------------------
// mmaf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mmaf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/mmaf_queue.sv =====
// ----------------------------------------------------------------------------
// mmaf_queue
// Short queue of decoded operations between the front and the back.
// ----------------------------------------------------------------------------
module mmaf_queue import mmaf_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  pop_op,
    output logic full,
    output logic empty
);
    op_t             slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg;
    logic [QP_W-1:0] rd_ptr_reg;
    logic [QC_W-1:0] count_reg;

    assign full   = (count_reg == QC_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/core/mmaf_front.sv =====
// ----------------------------------------------------------------------------
// mmaf_front
// Accepts requests, holds the configuration, tracks channel and ring slot,
// and turns each request into an operation for the back.
// ----------------------------------------------------------------------------
module mmaf_front import mmaf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mmaf_in_if.sink               in_ch,
    input  logic                  queue_full,
    output logic                  op_push,
    output op_t                   op,
    output cfg_t                  cfg
);
    logic [FRAC_W-1:0]     frac_reg;
    logic [LAGS_CFG_W-1:0] lags_reg;
    logic [CHAN_CFG_W-1:0] chans_reg;
    logic [CH_W-1:0]       chan_cnt_reg;
    logic [SLOT_W-1:0]     slot_reg;

    logic [NLAG_W-1:0] lags_eff;
    logic [NCH_W-1:0]  chans_eff;
    logic [CH_W-1:0]   cur_chan;
    logic              cur_last;
    logic              accept;
    logic              in_range;

    assign lags_eff  = (lags_reg == '0) ? NLAG_W'(1) :
                       (int'(lags_reg) > MAX_LAGS) ? NLAG_W'(MAX_LAGS) : NLAG_W'(lags_reg);
    assign chans_eff = (chans_reg == '0) ? NCH_W'(1) :
                       (int'(chans_reg) > CHANNELS) ? NCH_W'(CHANNELS) : NCH_W'(chans_reg);
    assign cfg = '{frac: frac_reg, lags: lags_eff, chans: chans_eff};

    // A counter left beyond the vector by a smaller channel count restarts at 0.
    assign cur_chan = (NCH_W'(chan_cnt_reg) >= chans_eff) ? '0 : chan_cnt_reg;
    assign cur_last = (NCH_W'(cur_chan) + 1'b1 >= chans_eff);

    assign in_ch.ready = !queue_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign in_range    = (int'(in_ch.data.coef_lag) < MAX_LAGS) &&
                         (int'(in_ch.data.coef_row) < CHANNELS) &&
                         (int'(in_ch.data.coef_col) < CHANNELS);

    always_comb
    begin
        op.kind       = OP_SAMPLE;
        op.coef_addr  = CA_W'((int'(in_ch.data.coef_lag) * CHANNELS
                             + int'(in_ch.data.coef_row)) * CHANNELS
                             + int'(in_ch.data.coef_col));
        op.coef_value = in_ch.data.coef_value;
        op.sample     = in_ch.data.sample_value;
        op.chan       = cur_chan;
        op.slot       = slot_reg;
        op.last       = cur_last;
        op_push       = 1'b0;
        unique case (in_ch.data.req_type)
            REQ_LOAD:
            begin
                op.kind = OP_LOAD;
                op_push = accept && in_range;
            end
            REQ_SAMPLE:
            begin
                op.kind = OP_SAMPLE;
                op_push = accept;
            end
            REQ_CLEAR:
            begin
                op.kind = OP_CLEAR;
                op_push = accept;
            end
            default:
            begin
                op_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg     <= FRAC_W'(14);
            lags_reg     <= LAGS_CFG_W'(8);
            chans_reg    <= CHAN_CFG_W'(4);
            chan_cnt_reg <= '0;
            slot_reg     <= '0;
        end
        else
        begin
            if (op_push && op.kind == OP_SAMPLE)
            begin
                if (cur_last)
                begin
                    chan_cnt_reg <= '0;
                    slot_reg     <= (slot_reg == SLOT_W'(SLOTS - 1)) ? '0 : slot_reg + 1'b1;
                end
                else
                begin
                    chan_cnt_reg <= cur_chan + 1'b1;
                end
            end
            else if (op_push && op.kind == OP_CLEAR)
            begin
                chan_cnt_reg <= '0;
                slot_reg     <= '0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FRAC:  frac_reg <= cfg_data[FRAC_W-1:0];
                    CFG_LAGS:  lags_reg <= cfg_data[LAGS_CFG_W-1:0];
                    CFG_CHANS:
                    begin
                        chans_reg    <= cfg_data[CHAN_CFG_W-1:0];
                        chan_cnt_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end
endmodule

// ===== rtl/core/mmaf_back.sv =====
// ----------------------------------------------------------------------------
// mmaf_back
// Executes operations: coefficient writes, history clears, and the
// multiply-accumulate walk over lags and channels for each sample.
// ----------------------------------------------------------------------------
module mmaf_back import mmaf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_empty,
    input  op_t       q_op,
    output logic      q_pop,
    mmaf_out_if.source out_ch
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_ROUND
    } state_t;

    localparam logic signed [ACC_W-1:0] S_MAX =
        {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] S_MIN = ~S_MAX;

    state_t                   state_reg;
    logic [CH_W-1:0]          r_reg;
    logic                     last_reg;
    logic [LAG_W-1:0]         j_reg;
    logic [CH_W-1:0]          c_reg;
    logic [SLOT_W-1:0]        s_reg;
    logic                     v1_reg;
    logic                     hv1_reg;
    logic                     v2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [HIST_DEPTH-1:0]    hist_valid_reg;
    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    logic                     coef_we;
    logic                     hist_we;
    logic [CA_W-1:0]          coef_raddr;
    logic [HA_W-1:0]          hist_raddr;
    logic [HA_W-1:0]          hist_waddr;
    logic [COEF_BITS-1:0]     coef_rd;
    logic [SAMPLE_BITS-1:0]   hist_rd;
    logic                     chan_end;
    logic                     lag_end;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-1:0]  shifted;
    logic                     sat;
    logic                     out_free;

    assign q_pop      = (state_reg == S_IDLE) && !q_empty;
    assign coef_we    = q_pop && (q_op.kind == OP_LOAD);
    assign hist_we    = q_pop && (q_op.kind == OP_SAMPLE);
    assign hist_waddr = HA_W'(int'(q_op.slot) * CHANNELS + int'(q_op.chan));
    assign coef_raddr = CA_W'((int'(j_reg) * CHANNELS + int'(r_reg)) * CHANNELS + int'(c_reg));
    assign hist_raddr = HA_W'(int'(s_reg) * CHANNELS + int'(c_reg));
    assign chan_end   = (NCH_W'(c_reg) + 1'b1 == cfg.chans);
    assign lag_end    = (NLAG_W'(j_reg) + 1'b1 == cfg.lags);
    assign out_free   = !out_valid_reg || out_ch.ready;

    mmaf_ram #(.WIDTH(COEF_BITS), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (q_op.coef_addr),
        .wdata (q_op.coef_value),
        .raddr (coef_raddr),
        .rdata (coef_rd)
    );

    mmaf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HIST_DEPTH)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (q_op.sample),
        .raddr (hist_raddr),
        .rdata (hist_rd)
    );

    // Round half up, then clip to the sample range.
    always_comb
    begin
        if (cfg.frac == '0)
        begin
            rounded = acc_reg;
        end
        else
        begin
            rounded = acc_reg + (ACC_W'(1) <<< (cfg.frac - 1'b1));
        end
        shifted = rounded >>> cfg.frac;
        sat     = (shifted > S_MAX) || (shifted < S_MIN);
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            r_reg          <= '0;
            last_reg       <= 1'b0;
            j_reg          <= '0;
            c_reg          <= '0;
            s_reg          <= '0;
            v1_reg         <= 1'b0;
            hv1_reg        <= 1'b0;
            v2_reg         <= 1'b0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            hist_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            v1_reg  <= (state_reg == S_MAC);
            hv1_reg <= hist_valid_reg[hist_raddr];
            v2_reg  <= v1_reg;
            if (v1_reg)
            begin
                if (hv1_reg)
                begin
                    prod_reg <= $signed(coef_rd) * $signed(hist_rd);
                end
                else
                begin
                    prod_reg <= '0;
                end
            end
            if (v2_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (out_valid_reg && out_ch.ready && state_reg != S_ROUND)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        unique case (q_op.kind)
                            OP_CLEAR:
                            begin
                                hist_valid_reg <= '0;
                            end
                            OP_SAMPLE:
                            begin
                                hist_valid_reg[hist_waddr] <= 1'b1;
                                r_reg     <= q_op.chan;
                                last_reg  <= q_op.last;
                                j_reg     <= '0;
                                c_reg     <= '0;
                                s_reg     <= (q_op.slot == '0) ? SLOT_W'(SLOTS - 1)
                                                               : q_op.slot - 1'b1;
                                acc_reg   <= ACC_W'(q_op.sample) <<< cfg.frac;
                                state_reg <= S_MAC;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_MAC:
                begin
                    if (chan_end)
                    begin
                        c_reg <= '0;
                        j_reg <= j_reg + 1'b1;
                        s_reg <= (s_reg == '0) ? SLOT_W'(SLOTS - 1) : s_reg - 1'b1;
                        if (lag_end)
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    if (out_free)
                    begin
                        out_valid_reg                   <= 1'b1;
                        out_data_reg.out_channel        <= OCH_W'(r_reg);
                        out_data_reg.out_saturated      <= sat;
                        out_data_reg.out_last_of_vector <= last_reg;
                        if (!sat)
                        begin
                            out_data_reg.out_value <= shifted[SAMPLE_BITS-1:0];
                        end
                        else if (shifted < 0)
                        begin
                            out_data_reg.out_value <= S_MIN[SAMPLE_BITS-1:0];
                        end
                        else
                        begin
                            out_data_reg.out_value <= S_MAX[SAMPLE_BITS-1:0];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Rounding must only see a fully drained accumulator.
    a_round_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROUND |-> !v1_reg && !v2_reg)
        else $error("rounding started with products in flight");

    // The channel walk never passes the configured channel count.
    a_chan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MAC |-> NCH_W'(c_reg) < cfg.chans)
        else $error("channel index beyond vector");

    // A new result is only produced by the rounding step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_ROUND))
        else $error("result raised outside rounding");

    // No memory write lands while a walk reads the stores.
    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC || state_reg == S_DRAIN) |-> !coef_we && !hist_we)
        else $error("store written during accumulation");
endmodule

// ===== rtl/core/multichannel_ma_filter.sv =====
// ----------------------------------------------------------------------------
// multichannel_ma_filter
// Multichannel moving-average filter: each sample is summed with the past
// vectors weighted by a coefficient matrix per lag, then rounded and clipped.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   -------   ---------  ---------------------------------------------------
//   in_ch     sink       request: load coefficient, sample, clear history
//   out_ch    source     one filtered sample per sample request
//   cfg_*     write      coef_frac_bits, lags_in_use, channels_in_use
//
// A sample request occupies the back end for a walk over lags * channels
// products: one shared multiply-accumulate walks every product of the
// coefficient and history memories, one per cycle, followed by a pipeline
// drain and a rounding step that waits for a free output register. Loads
// and clears leave the back end idle. Reset clears all control state and
// the history valid bits at once; the coefficient memory is undefined until
// written. A two-entry queue between front and back, and the output register,
// let requests keep arriving while a result waits for the consumer.
//
module multichannel_ma_filter import mmaf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mmaf_in_if.sink               in_ch,
    mmaf_out_if.source            out_ch
);
    // Decoded operations travel from the front through the queue.
    op_t  push_op;
    op_t  pop_op;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    cfg_t cfg;

    // The front owns configuration, channel counter and ring slot, so each
    // operation already knows where its sample lands in the history.
    mmaf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .queue_full (queue_full),
        .op_push    (push),
        .op         (push_op),
        .cfg        (cfg)
    );

    mmaf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    // The back holds both memories and the accumulator, and drives results
    // from its own output register.
    mmaf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (queue_empty),
        .q_op    (pop_op),
        .q_pop   (pop),
        .out_ch  (out_ch)
    );
endmodule
